@@ rtl/core/rlts_pkg.sv @@
// Shared types and command codes for the replicated log term store.
package rlts_pkg;

    typedef enum logic [2:0] {
        CMD_QUERY    = 3'd0,
        CMD_BSTART   = 3'd1,
        CMD_BENTRY   = 3'd2,
        CMD_APPEND   = 3'd3,
        CMD_VOTE     = 3'd4,
        CMD_TRUNCATE = 3'd5,
        CMD_COMPACT  = 3'd6,
        CMD_RESTORE  = 3'd7
    } t_cmd;

    localparam logic [1:0] ST_DONE    = 2'd0;
    localparam logic [1:0] ST_FULL    = 2'd1;
    localparam logic [1:0] ST_NOBATCH = 2'd2;

    localparam logic [47:0] IDX_MAX = 48'hFFFF_FFFF_FFFF;

    // One decoded command travelling from the front to the back.
    typedef struct packed {
        t_cmd        cmd;
        logic [47:0] pos;
        logic [31:0] term;
    } t_item;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_READ,
        BK_EXEC
    } t_bk_state;

endpackage

@@ rtl/core/rlts_front.sv @@
// Command front end: captures commands into a two-entry queue.
module rlts_front
    import rlts_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [2:0]  i_cmd,
    input  logic [47:0] i_log_position,
    input  logic [31:0] i_term_value,
    input  logic        i_pop,
    output logic        o_full,
    output logic        o_valid,
    output t_item       o_item
);

    t_item      r_q [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       w_push, w_pop;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_item  = r_q[r_rp];
    assign w_push  = i_start && !o_full;
    assign w_pop   = i_pop && o_valid;

    // Queue storage.
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= '{cmd: t_cmd'(i_cmd), pos: i_log_position, term: i_term_value};
        end
    end

    // Queue pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wp <= ~r_wp;
            if (w_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
    end

endmodule

@@ rtl/core/rlts_back.sv @@
// Command back end: ring memory, log bookkeeping and result generation.
module rlts_back
    import rlts_pkg::*;
#(
    parameter int LOG_DEPTH = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  t_item       i_item,
    output logic        o_pop,
    output logic        o_done,
    output logic        o_ok,
    output logic [1:0]  o_status,
    output logic        o_term_known,
    output logic [31:0] o_found_term,
    output logic [47:0] o_result_index,
    output logic [47:0] o_last_index,
    output logic [31:0] o_last_term
);

    localparam int AW = $clog2(LOG_DEPTH);
    localparam int CW = AW + 1;
    localparam logic [CW-1:0] DEPTH_C = CW'(LOG_DEPTH);

    logic [31:0]   r_ring [LOG_DEPTH];
    logic [31:0]   r_rd;
    logic [AW-1:0] r_head;
    logic [CW-1:0] r_count;
    logic [47:0]   r_bidx;
    logic [31:0]   r_bterm;
    logic          r_bacc;
    logic [47:0]   r_bnext;
    logic [31:0]   r_lterm;
    t_item         r_it;
    t_bk_state     r_state, n_state;

    logic [AW-1:0] n_head;
    logic [CW-1:0] n_count;
    logic [47:0]   n_bidx;
    logic [31:0]   n_bterm, n_lterm;
    logic          n_bacc;
    logic [47:0]   n_bnext;
    logic          n_ok, n_known;
    logic [1:0]    n_status;
    logic [31:0]   n_found;
    logic [47:0]   n_ridx;
    logic          w_we;
    logic [AW-1:0] w_waddr, w_raddr;

    logic [47:0]   w_last, w_qidx, w_off, w_cut_cnt, w_clamp;
    logic          w_in_ring, w_hit_b, w_known;
    logic [31:0]   w_lk;

    logic          r_ok, r_known, r_done;
    logic [1:0]    r_status;
    logic [31:0]   r_found;
    logic [47:0]   r_ridx;

    // Ring slot at an offset from a base slot, wrapped at the ring depth.
    function automatic logic [AW-1:0] f_slot(input logic [AW-1:0] base,
                                             input logic [CW-1:0] off);
        logic [CW-1:0] s;
        s = {1'b0, base} + off;
        if (s >= DEPTH_C) s = s - DEPTH_C;
        return s[AW-1:0];
    endfunction

    assign w_last = r_bidx + 48'(r_count);

    // Index that the command looks up in the ring; truncate reads the new last entry.
    always_comb begin
        case (i_item.cmd)
            CMD_BENTRY: w_qidx = r_bnext;
            CMD_COMPACT: w_qidx = (i_item.pos < w_last) ? i_item.pos : w_last;
            CMD_TRUNCATE: w_qidx = i_item.pos - 48'd1;
            default: w_qidx = i_item.pos;
        endcase
    end
    assign w_off   = w_qidx - r_bidx - 48'd1;
    assign w_raddr = f_slot(r_head, CW'(w_off));

    // Lookup on the latched command with the registered ring data.
    always_comb begin
        logic [47:0] q;
        q = (r_it.cmd == CMD_BENTRY) ? r_bnext
          : (r_it.cmd == CMD_COMPACT) ? ((r_it.pos < w_last) ? r_it.pos : w_last)
          : r_it.pos;
        w_clamp   = q;
        w_hit_b   = (q == r_bidx);
        w_in_ring = (q > r_bidx) && (q <= w_last);
        w_known   = w_hit_b || w_in_ring;
        w_lk      = w_hit_b ? r_bterm : (w_in_ring ? r_rd : 32'd0);
    end
    assign w_cut_cnt = r_it.pos - r_bidx - 48'd1;

    // Back end sequencer: read the ring, then execute and update.
    always_comb begin
        logic full;
        logic [CW-1:0] cnt2;
        logic [47:0]   k;
        n_state  = r_state;
        n_head   = r_head;
        n_count  = r_count;
        n_bidx   = r_bidx;
        n_bterm  = r_bterm;
        n_lterm  = r_lterm;
        n_bacc   = r_bacc;
        n_bnext  = r_bnext;
        n_ok     = 1'b0;
        n_known  = 1'b0;
        n_status = ST_DONE;
        n_found  = 32'd0;
        n_ridx   = 48'd0;
        w_we     = 1'b0;
        w_waddr  = '0;
        o_pop    = 1'b0;
        full     = 1'b0;
        cnt2     = r_count;
        k        = 48'd0;
        unique case (r_state)
            BK_IDLE: begin
                if (i_valid) begin
                    o_pop   = 1'b1;
                    n_state = BK_EXEC;
                end
            end
            BK_READ: n_state = BK_EXEC;
            BK_EXEC: begin
                n_state = BK_IDLE;
                unique case (r_it.cmd)
                    CMD_QUERY: begin
                        n_known = w_known;
                        n_ok    = w_known;
                        n_found = w_lk;
                    end
                    CMD_BSTART: begin
                        n_bacc   = w_known && (w_lk == r_it.term);
                        n_bnext  = r_it.pos + 48'd1;
                        n_ok     = n_bacc;
                        n_status = n_bacc ? ST_DONE : ST_NOBATCH;
                        n_ridx   = r_it.pos;
                    end
                    CMD_BENTRY: begin
                        if (!r_bacc) begin
                            n_status = ST_NOBATCH;
                        end else if ((r_bnext <= r_bidx)
                                     || (w_known && w_lk == r_it.term)) begin
                            n_ok    = 1'b1;
                            n_ridx  = r_bnext;
                            n_bnext = r_bnext + 48'd1;
                        end else if ({1'b0, r_bnext} > {1'b0, w_last} + 49'd1) begin
                            n_bacc   = 1'b0;
                            n_status = ST_NOBATCH;
                            n_ridx   = r_bnext;
                        end else begin
                            // Index lies in (boundary, last+1]: truncate, then push unless the log is full.
                            cnt2 = CW'(r_bnext - r_bidx - 48'd1);
                            if (cnt2 >= DEPTH_C || (r_bidx + 48'(cnt2)) >= IDX_MAX) begin
                                n_count  = cnt2;
                                n_status = ST_FULL;
                                if (cnt2 != r_count) begin
                                    n_lterm = (cnt2 == '0) ? r_bterm : r_lterm;
                                end
                            end else begin
                                w_we    = 1'b1;
                                w_waddr = f_slot(r_head, cnt2);
                                n_count = cnt2 + CW'(1);
                                n_lterm = r_it.term;
                                n_ok    = 1'b1;
                            end
                            n_ridx  = r_bnext;
                            n_bnext = r_bnext + 48'd1;
                        end
                    end
                    CMD_APPEND: begin
                        full = (r_count >= DEPTH_C) || (w_last >= IDX_MAX);
                        if (full) begin
                            n_status = ST_FULL;
                            n_ridx   = w_last;
                        end else begin
                            w_we    = 1'b1;
                            w_waddr = f_slot(r_head, r_count);
                            n_count = r_count + CW'(1);
                            n_lterm = r_it.term;
                            n_ok    = 1'b1;
                            n_ridx  = w_last + 48'd1;
                        end
                    end
                    CMD_VOTE: begin
                        if (r_it.term != r_lterm) n_ok = r_it.term > r_lterm;
                        else                      n_ok = r_it.pos >= w_last;
                    end
                    CMD_TRUNCATE: begin
                        if ({1'b0, r_it.pos} <= {1'b0, r_bidx} + 49'd1) begin
                            n_count = '0;
                            n_lterm = r_bterm;
                        end else if (r_it.pos <= w_last) begin
                            n_count = CW'(w_cut_cnt);
                            n_lterm = r_rd;
                        end
                    end
                    CMD_COMPACT: begin
                        if (r_it.pos > r_bidx) begin
                            k       = w_clamp - r_bidx;
                            n_head  = f_slot(r_head, CW'(k));
                            n_count = r_count - CW'(k);
                            n_bidx  = w_clamp;
                            n_bterm = w_known ? w_lk : r_bterm;
                            if (n_count == '0) n_lterm = n_bterm;
                        end
                    end
                    CMD_RESTORE: begin
                        n_count = '0;
                        n_head  = '0;
                        n_bidx  = r_it.pos;
                        n_bterm = r_it.term;
                        n_lterm = r_it.term;
                    end
                    default: ;
                endcase
            end
            default: n_state = BK_IDLE;
        endcase
    end

    // Ring memory: one port, read when a command is taken, write on execute.
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_ring[w_waddr] <= r_it.term;
        end else if (o_pop) begin
            r_rd <= r_ring[w_raddr];
        end
    end

    // Latched command and result payload.
    always_ff @(posedge i_clk) begin
        if (o_pop) r_it <= i_item;
        r_ok     <= n_ok;
        r_known  <= n_known;
        r_status <= n_status;
        r_found  <= n_found;
        r_ridx   <= n_ridx;
    end

    // Log bookkeeping and control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BK_IDLE;
            r_head  <= '0;
            r_count <= '0;
            r_bidx  <= '0;
            r_bterm <= '0;
            r_lterm <= '0;
            r_bacc  <= 1'b0;
            r_bnext <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_count <= n_count;
            r_bidx  <= n_bidx;
            r_bterm <= n_bterm;
            r_lterm <= n_lterm;
            r_bacc  <= n_bacc;
            r_bnext <= n_bnext;
            r_done  <= (r_state == BK_EXEC);
        end
    end

    assign o_done         = r_done;
    assign o_ok           = r_ok;
    assign o_status       = r_status;
    assign o_term_known   = r_known;
    assign o_found_term   = r_found;
    assign o_result_index = r_ridx;
    assign o_last_index   = w_last;
    assign o_last_term    = r_lterm;

endmodule

@@ rtl/core/replicated_log_term_store_core.sv @@
// Top level of the replicated log term store.
//
// Usage: drive i_cmd, i_log_position and i_term_value with start high; the
// transaction is taken at the edge where start is high and busy is low.
// Commands land in a two-entry queue; the back end pulls one at a time.
// Each command produces exactly one result, shown for one cycle with
// o_done high; the receiver cannot stall it.
// A taken command waits in the queue until the idle back end pops it and
// reads the ring; it then executes, and o_done is registered from execute.
// The back end takes a new command only after executing the last one, set
// by the read then execute-and-write sequence on the single-port ring memory.
// o_last_index and o_last_term track the log state after the command.
// Reset (i_rst_n low, synchronous) empties the log, sets the boundary
// index and term to zero and drops queued commands. Ring contents are not
// cleared; only slots below the entry count are ever read.
module replicated_log_term_store_core
    import rlts_pkg::*;
#(
    parameter int LOG_DEPTH = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  i_cmd,
    input  logic [47:0] i_log_position,
    input  logic [31:0] i_term_value,
    output logic        o_done,
    output logic        o_ok,
    output logic [1:0]  o_status,
    output logic        o_term_known,
    output logic [31:0] o_found_term,
    output logic [47:0] o_result_index,
    output logic [47:0] o_last_index,
    output logic [31:0] o_last_term
);

    logic  w_pop, w_valid;
    t_item w_item;

    rlts_front u_front (
        .i_clk, .i_rst_n,
        .i_start(start), .i_cmd, .i_log_position, .i_term_value,
        .i_pop(w_pop), .o_full(busy), .o_valid(w_valid), .o_item(w_item)
    );

    rlts_back #(.LOG_DEPTH(LOG_DEPTH)) u_back (
        .i_clk, .i_rst_n,
        .i_valid(w_valid), .i_item(w_item), .o_pop(w_pop),
        .o_done, .o_ok, .o_status, .o_term_known, .o_found_term,
        .o_result_index, .o_last_index, .o_last_term
    );

    // A result never reports a term as found without knowing it.
    a_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && !o_term_known |-> o_found_term == 32'd0)
        else $error("found term without known index");

    // Status code stays in its defined range.
    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> o_status != 2'd3)
        else $error("bad status code");

    // A result with o_ok high never carries a failure status.
    a_okst: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_ok |-> o_status == ST_DONE)
        else $error("ok with failure status");

endmodule
